// File: src/bcl_pkg.sv
// Package: shared types and constants for the circular list block
`timescale 1ns / 1ps
package bcl_pkg;
  localparam int CAPACITY_DEF = 128;
  localparam int RECORD_WIDTH_DEF = 32;
  localparam int OP_W = 4;
  localparam int POS_W = 7;
  localparam int STATUS_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_ADD = 4'd0, OP_REMOVE = 4'd1, OP_OLDER = 4'd2, OP_NEWER = 4'd3,
    OP_SET = 4'd4, OP_READ = 4'd5, OP_RDCUR = 4'd6, OP_COUNT = 4'd7,
    OP_CLEAR = 4'd8
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK = 2'd0, ST_EMPTY = 2'd1, ST_RANGE = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_FREE, S_RD1, S_WAIT1, S_RD2, S_WAIT2, S_WR1, S_WR2, S_WALK,
    S_WALKW, S_RDREC, S_RECW, S_DONE
  } state_t;
endpackage

// File: src/bounded_circular_list_with_cursor_core.sv
// Top level: circular newest-to-oldest list with cursor, linked in memory
`timescale 1ns / 1ps
// Channel | Ports                                      | Handshake
// in      | in_operation, in_position, in_record_in    | start & !busy
// out     | out_status, out_record_out, out_entries_held | out_valid, one cycle
// Busy path from accept to S_DONE: count, clear, unknown codes and errors go there
//   at once; cursor steps and read cursor read the links, then the record; remove
//   reads the links, then rewrites two (not for the last record); an add to a full
//   list reuses the oldest slot, other adds scan slot_used (one bit per cycle) up to
//   the lowest free slot. Set cursor and read index follow position older links from
//   newest, each step waiting out the registered read of the link memory.
// Reset: rst_n synchronous; clears list pointers, count and slot bits.
// Stalls: busy is high from accept until the result strobe, which comes in the
//   first idle cycle; a new item may be accepted in that cycle. No output stall.
module bounded_circular_list_with_cursor_core #(
  parameter int CAPACITY = bcl_pkg::CAPACITY_DEF,
  parameter int RECORD_WIDTH = bcl_pkg::RECORD_WIDTH_DEF,
  localparam int SW = $clog2(CAPACITY),
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [bcl_pkg::OP_W-1:0]     in_operation,
  input  logic [bcl_pkg::POS_W-1:0]    in_position,
  input  logic [RECORD_WIDTH-1:0]      in_record_in,
  output logic                         out_valid,
  output logic [bcl_pkg::STATUS_W-1:0] out_status,
  output logic [RECORD_WIDTH-1:0]      out_record_out,
  output logic [CW-1:0]                out_entries_held
);
  bcl_pkg::state_t state_r, state_nxt;
  logic [bcl_pkg::OP_W-1:0] op_r, op_nxt;
  logic [bcl_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic [RECORD_WIDTH-1:0] rec_r, rec_nxt;
  logic [SW-1:0] newest_r, newest_nxt, oldest_r, oldest_nxt, cur_r, cur_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CAPACITY-1:0] used_r, used_nxt;
  logic [SW-1:0] slot_r, slot_nxt;   // slot worked on
  logic [SW-1:0] o_r, o_nxt, n_r, n_nxt; // saved neighbors
  logic [CW-1:0] step_r, step_nxt;
  logic [bcl_pkg::STATUS_W-1:0] st_r, st_nxt;
  logic [RECORD_WIDTH-1:0] ro_r, ro_nxt;
  logic ov_r, ov_nxt;

  logic [SW-1:0] rd_addr, wr_addr, wr_older, wr_newer;
  logic [RECORD_WIDTH-1:0] rd_rec;
  logic [SW-1:0] rd_older, rd_newer;
  logic we_rec, we_older, we_newer;

  bcl_mem #(.CAPACITY(CAPACITY), .RECORD_WIDTH(RECORD_WIDTH)) u_mem (
    .clk, .rd_addr, .rd_rec, .rd_older, .rd_newer, .we_rec, .we_older,
    .we_newer, .wr_addr, .wr_rec(rec_r), .wr_older, .wr_newer
  );

  assign busy = (state_r != bcl_pkg::S_IDLE);
  assign out_valid = ov_r;
  assign out_status = st_r;
  assign out_record_out = ro_r;
  assign out_entries_held = count_r;

  // control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bcl_pkg::S_IDLE;
      newest_r <= '0; oldest_r <= '0; cur_r <= '0; count_r <= '0;
      used_r <= '0; ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      newest_r <= newest_nxt; oldest_r <= oldest_nxt; cur_r <= cur_nxt;
      count_r <= count_nxt; used_r <= used_nxt; ov_r <= ov_nxt;
    end
  end

  // item payload and scratch
  always_ff @(posedge clk) begin
    op_r <= op_nxt; pos_r <= pos_nxt; rec_r <= rec_nxt;
    slot_r <= slot_nxt; o_r <= o_nxt; n_r <= n_nxt; step_r <= step_nxt;
    st_r <= st_nxt; ro_r <= ro_nxt;
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    op_nxt = op_r; pos_nxt = pos_r; rec_nxt = rec_r;
    newest_nxt = newest_r; oldest_nxt = oldest_r; cur_nxt = cur_r;
    count_nxt = count_r; used_nxt = used_r;
    slot_nxt = slot_r; o_nxt = o_r; n_nxt = n_r; step_nxt = step_r;
    st_nxt = st_r; ro_nxt = ro_r; ov_nxt = 1'b0;
    rd_addr = slot_r; wr_addr = slot_r; wr_older = '0; wr_newer = '0;
    we_rec = 1'b0; we_older = 1'b0; we_newer = 1'b0;
    unique case (state_r)
      bcl_pkg::S_IDLE: begin
        if (start) begin
          op_nxt = in_operation; pos_nxt = in_position; rec_nxt = in_record_in;
          st_nxt = bcl_pkg::ST_OK; ro_nxt = '0; step_nxt = '0;
          state_nxt = bcl_pkg::S_DONE;
          case (in_operation)
            bcl_pkg::OP_ADD: begin
              if (count_r == CW'(CAPACITY)) begin
                slot_nxt = oldest_r; state_nxt = bcl_pkg::S_RD1;
              end else begin
                slot_nxt = '0; state_nxt = bcl_pkg::S_FREE;
              end
            end
            bcl_pkg::OP_REMOVE, bcl_pkg::OP_OLDER, bcl_pkg::OP_NEWER,
            bcl_pkg::OP_RDCUR: begin
              if (count_r == '0) st_nxt = bcl_pkg::ST_EMPTY;
              else begin
                slot_nxt = cur_r; state_nxt = bcl_pkg::S_RD1;
              end
            end
            bcl_pkg::OP_SET, bcl_pkg::OP_READ: begin
              if (count_r == '0) st_nxt = bcl_pkg::ST_EMPTY;
              else if (int'(in_position) >= int'(count_r)) st_nxt = bcl_pkg::ST_RANGE;
              else begin
                slot_nxt = newest_r; state_nxt = bcl_pkg::S_WALK;
              end
            end
            bcl_pkg::OP_CLEAR: begin
              used_nxt = '0; newest_nxt = '0; oldest_nxt = '0; cur_nxt = '0;
              count_nxt = '0;
            end
            default: ;
          endcase
        end
      end
      // scan slot_used for the lowest free slot
      bcl_pkg::S_FREE: begin
        if (!used_r[slot_r]) begin
          if (count_r == '0) begin
            we_older = 1'b1; we_newer = 1'b1; we_rec = 1'b1;
            wr_older = slot_r; wr_newer = slot_r;
            newest_nxt = slot_r; oldest_nxt = slot_r; cur_nxt = slot_r;
            count_nxt = CW'(1); used_nxt[slot_r] = 1'b1;
            state_nxt = bcl_pkg::S_DONE;
          end else begin
            count_nxt = count_r + CW'(1);
            state_nxt = bcl_pkg::S_WR1;
          end
        end else slot_nxt = slot_r + SW'(1);
      end
      bcl_pkg::S_RD1: state_nxt = bcl_pkg::S_WAIT1;
      bcl_pkg::S_WAIT1: begin
        o_nxt = rd_older; n_nxt = rd_newer;
        case (op_r)
          bcl_pkg::OP_ADD: begin
            oldest_nxt = rd_newer; state_nxt = bcl_pkg::S_WR1;
          end
          bcl_pkg::OP_REMOVE: begin
            if (count_r == CW'(1)) begin
              cur_nxt = '0; newest_nxt = '0; oldest_nxt = '0;
              used_nxt[slot_r] = 1'b0; count_nxt = '0;
              state_nxt = bcl_pkg::S_DONE;
            end else begin
              if (slot_r == newest_r) begin
                cur_nxt = rd_older; newest_nxt = rd_older;
              end else if (slot_r == oldest_r) begin
                cur_nxt = rd_newer; oldest_nxt = rd_newer;
              end else cur_nxt = rd_newer;
              used_nxt[slot_r] = 1'b0; count_nxt = count_r - CW'(1);
              state_nxt = bcl_pkg::S_WR1;
            end
          end
          default: begin
            if (op_r == bcl_pkg::OP_OLDER) slot_nxt = rd_older;
            else if (op_r == bcl_pkg::OP_NEWER) slot_nxt = rd_newer;
            state_nxt = bcl_pkg::S_RDREC;
          end
        endcase
      end
      // link writes: add splices in at head, remove unlinks
      bcl_pkg::S_WR1: begin
        if (op_r == bcl_pkg::OP_ADD) begin
          we_rec = 1'b1; we_older = 1'b1; we_newer = 1'b1;
          wr_older = newest_r; wr_newer = oldest_r;
          used_nxt[slot_r] = 1'b1; cur_nxt = slot_r;
          rd_addr = newest_r;
        end else begin
          wr_addr = n_r; we_older = 1'b1; wr_older = o_r;
        end
        state_nxt = bcl_pkg::S_RD2;
      end
      bcl_pkg::S_RD2: begin
        if (op_r == bcl_pkg::OP_ADD) begin
          wr_addr = newest_r; we_newer = 1'b1; wr_newer = slot_r;
          state_nxt = bcl_pkg::S_WR2;
        end else begin
          wr_addr = o_r; we_newer = 1'b1; wr_newer = n_r;
          state_nxt = bcl_pkg::S_DONE;
        end
      end
      bcl_pkg::S_WR2: begin
        wr_addr = oldest_r; we_older = 1'b1; wr_older = slot_r;
        newest_nxt = slot_r; state_nxt = bcl_pkg::S_DONE;
      end
      // walk older links from newest
      bcl_pkg::S_WALK: begin
        if (step_r == CW'(pos_r)) state_nxt = bcl_pkg::S_RDREC;
        else state_nxt = bcl_pkg::S_WALKW;
      end
      bcl_pkg::S_WALKW: begin
        slot_nxt = rd_older; step_nxt = step_r + CW'(1);
        state_nxt = bcl_pkg::S_WALK;
      end
      bcl_pkg::S_RDREC: state_nxt = bcl_pkg::S_RECW;
      bcl_pkg::S_RECW: begin
        ro_nxt = rd_rec;
        if (op_r != bcl_pkg::OP_READ) cur_nxt = slot_r;
        state_nxt = bcl_pkg::S_DONE;
      end
      bcl_pkg::S_DONE: begin
        ov_nxt = 1'b1; state_nxt = bcl_pkg::S_IDLE;
      end
      default: state_nxt = bcl_pkg::S_IDLE;
    endcase
  end

  // checks
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY)) else $error("count over capacity");
  a_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("strobe while busy");
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == bcl_pkg::S_DONE |=> out_valid) else $error("missing strobe");
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_entries_held == '0) |-> (used_r == '0))
    else $error("slots used with empty list");
endmodule

// File: src/bcl_mem.sv
// Memory: record words and older/newer links, one read and one write port each
`timescale 1ns / 1ps
module bcl_mem #(
  parameter int CAPACITY = bcl_pkg::CAPACITY_DEF,
  parameter int RECORD_WIDTH = bcl_pkg::RECORD_WIDTH_DEF,
  localparam int SW = $clog2(CAPACITY)
) (
  input  logic                    clk,
  input  logic [SW-1:0]           rd_addr,
  output logic [RECORD_WIDTH-1:0] rd_rec,
  output logic [SW-1:0]           rd_older,
  output logic [SW-1:0]           rd_newer,
  input  logic                    we_rec,
  input  logic                    we_older,
  input  logic                    we_newer,
  input  logic [SW-1:0]           wr_addr,
  input  logic [RECORD_WIDTH-1:0] wr_rec,
  input  logic [SW-1:0]           wr_older,
  input  logic [SW-1:0]           wr_newer
);
  logic [RECORD_WIDTH-1:0] rec_mem [CAPACITY];
  logic [SW-1:0] older_mem [CAPACITY];
  logic [SW-1:0] newer_mem [CAPACITY];

  // registered reads
  always_ff @(posedge clk) begin
    rd_rec   <= rec_mem[rd_addr];
    rd_older <= older_mem[rd_addr];
    rd_newer <= newer_mem[rd_addr];
  end

  // writes
  always_ff @(posedge clk) begin
    if (we_rec) rec_mem[wr_addr] <= wr_rec;
    if (we_older) older_mem[wr_addr] <= wr_older;
    if (we_newer) newer_mem[wr_addr] <= wr_newer;
  end
endmodule

// File: tb/bounded_circular_list_with_cursor_core_test.sv
// Testbench for the circular list block: directed and random item streams
`timescale 1ns / 1ps
module bounded_circular_list_with_cursor_core_test;
  localparam int CAP = bcl_pkg::CAPACITY_DEF;
  localparam int WATCHDOG_LIMIT = 4000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [bcl_pkg::OP_W-1:0] in_operation = '0;
  logic [bcl_pkg::POS_W-1:0] in_position = '0;
  logic [31:0] in_record_in = '0;
  logic out_valid;
  logic [bcl_pkg::STATUS_W-1:0] out_status;
  logic [31:0] out_record_out;
  logic [7:0] out_entries_held;

  bounded_circular_list_with_cursor_core dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_operation(in_operation), .in_position(in_position),
    .in_record_in(in_record_in), .out_valid(out_valid),
    .out_status(out_status), .out_record_out(out_record_out),
    .out_entries_held(out_entries_held)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  typedef struct packed {
    logic [bcl_pkg::STATUS_W-1:0] status;
    logic [31:0] rec;
    logic [7:0] held;
  } list_result_t;

  // Predictor state: list kept as a simple array, index 0 = newest
  logic [31:0] list_recs[$];
  int cursor_idx;
  list_result_t pending_results[$];
  int errors = 0;
  int idle_cycles = 0;
  int sent_items = 0;
  int checked_items = 0;
  int send_gap_pct = 0;

  // Expected result of one item; updates the predicted list
  function automatic list_result_t predict_list_op(logic [3:0] op, logic [6:0] pos,
                                                   logic [31:0] rec);
    list_result_t r;
    int n;
    r = '0;
    n = list_recs.size();
    case (op)
      bcl_pkg::OP_ADD: begin
        if (n >= CAP) void'(list_recs.pop_back());
        list_recs.push_front(rec);
        cursor_idx = 0;
      end
      bcl_pkg::OP_REMOVE: begin
        if (n == 0) r.status = bcl_pkg::ST_EMPTY;
        else begin
          list_recs.delete(cursor_idx);
          if (n == 1) cursor_idx = 0;
          else if (cursor_idx != 0) cursor_idx = cursor_idx - 1;
        end
      end
      bcl_pkg::OP_OLDER, bcl_pkg::OP_NEWER, bcl_pkg::OP_RDCUR: begin
        if (n == 0) r.status = bcl_pkg::ST_EMPTY;
        else begin
          if (op == bcl_pkg::OP_OLDER) cursor_idx = (cursor_idx + 1) % n;
          if (op == bcl_pkg::OP_NEWER) cursor_idx = (cursor_idx + n - 1) % n;
          r.rec = list_recs[cursor_idx];
        end
      end
      bcl_pkg::OP_SET, bcl_pkg::OP_READ: begin
        if (n == 0) r.status = bcl_pkg::ST_EMPTY;
        else if (pos >= n) r.status = bcl_pkg::ST_RANGE;
        else begin
          if (op == bcl_pkg::OP_SET) cursor_idx = pos;
          r.rec = list_recs[pos];
        end
      end
      bcl_pkg::OP_CLEAR: begin
        list_recs.delete();
        cursor_idx = 0;
      end
      default: ;
    endcase
    r.held = 8'(list_recs.size());
    return r;
  endfunction

  // Send one item, with an optional random gap before it
  task automatic send_item(logic [3:0] op, logic [6:0] pos, logic [31:0] rec);
    while ($urandom_range(99) < send_gap_pct) @(posedge clk);
    in_operation <= op;
    in_position <= pos;
    in_record_in <= rec;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(predict_list_op(op, pos, rec));
    sent_items++;
    start <= 1'b0;
    @(posedge clk);
  endtask

  // Result checker
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      checked_items++;
      if (pending_results.size() == 0) begin
        $error("unexpected result: status %0d record %h held %0d",
               out_status, out_record_out, out_entries_held);
        errors++;
      end else begin
        list_result_t e;
        e = pending_results.pop_front();
        if (out_status !== e.status) begin
          $error("status: expected %0d actual %0d", e.status, out_status);
          errors++;
        end
        if (out_record_out !== e.rec) begin
          $error("record_out: expected %h actual %h", e.rec, out_record_out);
          errors++;
        end
        if (out_entries_held !== e.held) begin
          $error("entries_held: expected %0d actual %0d", e.held, out_entries_held);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles with no accepted item or result
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout after %0d quiet cycles", idle_cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Extremes, every operation, empty and range errors, unknown codes
  task automatic test_directed();
    send_item(bcl_pkg::OP_REMOVE, 7'd0, 32'd0);
    send_item(bcl_pkg::OP_OLDER, 7'd0, 32'd0);
    send_item(bcl_pkg::OP_NEWER, 7'd0, 32'd0);
    send_item(bcl_pkg::OP_SET, 7'd0, 32'd0);
    send_item(bcl_pkg::OP_READ, 7'd127, 32'd0);
    send_item(bcl_pkg::OP_RDCUR, 7'd0, 32'd0);
    send_item(bcl_pkg::OP_COUNT, 7'd0, 32'd0);
    send_item(bcl_pkg::OP_ADD, 7'd127, 32'hFFFF_FFFF);
    send_item(bcl_pkg::OP_ADD, 7'd0, 32'h0000_0000);
    send_item(bcl_pkg::OP_ADD, 7'd0, 32'hA5A5_5A5A);
    send_item(bcl_pkg::OP_READ, 7'd3, 32'd0);
    send_item(bcl_pkg::OP_READ, 7'd2, 32'd0);
    send_item(bcl_pkg::OP_SET, 7'd1, 32'd0);
    send_item(bcl_pkg::OP_NEWER, 7'd0, 32'd0);
    send_item(bcl_pkg::OP_NEWER, 7'd0, 32'd0);
    send_item(bcl_pkg::OP_OLDER, 7'd0, 32'd0);
    send_item(bcl_pkg::OP_REMOVE, 7'd0, 32'd0);
    send_item(bcl_pkg::OP_SET, 7'd1, 32'd0);
    send_item(bcl_pkg::OP_REMOVE, 7'd0, 32'd0);
    send_item(bcl_pkg::OP_REMOVE, 7'd0, 32'd0);
    send_item(4'd9, 7'd5, 32'h1234_5678);
    send_item(4'd15, 7'd127, 32'hFFFF_FFFF);
    send_item(bcl_pkg::OP_ADD, 7'd0, 32'h5555_AAAA);
    send_item(bcl_pkg::OP_CLEAR, 7'd0, 32'd0);
    send_item(bcl_pkg::OP_RDCUR, 7'd0, 32'd0);
  endtask

  // Fill past capacity so the oldest records are evicted, then walk deep
  task automatic test_full_list();
    for (int i = 0; i < CAP + 6; i++) send_item(bcl_pkg::OP_ADD, 7'($urandom), $urandom);
    send_item(bcl_pkg::OP_READ, 7'd127, 32'd0);
    send_item(bcl_pkg::OP_SET, 7'd127, 32'd0);
    send_item(bcl_pkg::OP_OLDER, 7'd0, 32'd0);
    send_item(bcl_pkg::OP_REMOVE, 7'd0, 32'd0);
    send_item(bcl_pkg::OP_READ, 7'd127, 32'd0);
    send_item(bcl_pkg::OP_SET, 7'd64, 32'd0);
    send_item(bcl_pkg::OP_REMOVE, 7'd0, 32'd0);
    send_item(bcl_pkg::OP_CLEAR, 7'd0, 32'd0);
  endtask

  // Random mix; positions mostly within the count to keep walks short
  task automatic test_random(int count);
    logic [3:0] op;
    logic [6:0] pos;
    int n;
    int pick;
    for (int i = 0; i < count; i++) begin
      n = list_recs.size();
      pick = $urandom_range(99);
      if (pick < 30) op = bcl_pkg::OP_ADD;
      else if (pick < 42) op = bcl_pkg::OP_REMOVE;
      else if (pick < 50) op = bcl_pkg::OP_OLDER;
      else if (pick < 58) op = bcl_pkg::OP_NEWER;
      else if (pick < 68) op = bcl_pkg::OP_SET;
      else if (pick < 78) op = bcl_pkg::OP_READ;
      else if (pick < 86) op = bcl_pkg::OP_RDCUR;
      else if (pick < 92) op = bcl_pkg::OP_COUNT;
      else if (pick < 94) op = bcl_pkg::OP_CLEAR;
      else op = 4'($urandom_range(15));
      if (n > 0 && $urandom_range(9) < 8) pos = 7'($urandom_range(n - 1));
      else pos = 7'($urandom);
      send_item(op, pos, $urandom);
    end
  endtask

  initial begin
    cursor_idx = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_gap_pct = 32;
    test_directed();
    test_full_list();
    test_random(410);
    send_gap_pct = 54;
    test_random(410);
    send_gap_pct = 0;
    test_random(410);
    wait_drained();
    $display("sent %0d items, checked %0d results (errors, wrap, eviction, random mix)",
             sent_items, checked_items);
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule
